/* rtl/acob_pkg.sv */
// acob_pkg: shared types and constants for the alpha compositing block
// no dependencies; used by acob_blend and alpha_composite_over_background

package acob_pkg;

	localparam int unsigned ADDR_W = 4;
	localparam int unsigned DATA_W = 32;

	localparam logic [1:0] REG_FILL_MODE      = 2'd0;
	localparam logic [1:0] REG_BACKGROUND_RGB = 2'd1;
	localparam logic [1:0] REG_IMAGE_WIDTH    = 2'd2;

	localparam logic [1:0] MODE_PASS    = 2'd0;
	localparam logic [1:0] MODE_SOLID   = 2'd1;
	localparam logic [1:0] MODE_CHECKER = 2'd2;

	localparam logic [7:0] GRAY_LIGHT = 8'd160;
	localparam logic [7:0] GRAY_DARK  = 8'd96;
	localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

	localparam logic [15:0] WIDTH_RESET = 16'd1;

	typedef struct packed {
		logic load_s2;
		logic load_out;
	} blend_ctl_t;

endpackage

/* rtl/acob_blend.sv */
// acob_blend: two-stage datapath, per-channel multiply then divide by 255 and offset
// depends on acob_pkg for blend_ctl_t and constants

module acob_blend import acob_pkg::*; (
	input  logic        clk,
	input  blend_ctl_t  ctl,
	input  logic [31:0] pixel_s1,
	input  logic [23:0] bg_s1,
	input  logic        bypass_s1,
	output logic [31:0] pixel_out
);

	logic [31:0]      pixel_s2;
	logic [23:0]      bg_s2;
	logic             pass_s2;
	logic [2:0]       neg_s2;
	logic [2:0][15:0] prod_s2;

	logic [2:0]       neg_d;
	logic [2:0][15:0] prod_d;
	logic [23:0]      blended;
	logic [31:0]      result_d;

	always_comb begin
		logic [7:0] c;
		logic [7:0] b;
		logic [7:0] mag;
		for (int i = 0; i < 3; i++) begin
			c = pixel_s1[8*i +: 8];
			b = bg_s1[8*i +: 8];
			neg_d[i] = (c < b);
			mag = neg_d[i] ? (b - c) : (c - b);
			prod_d[i] = pixel_s1[31:24] * mag;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load_s2) begin
			pixel_s2 <= pixel_s1;
			bg_s2    <= bg_s1;
			pass_s2  <= bypass_s1 || (pixel_s1[31:24] == ALPHA_OPAQUE);
			neg_s2   <= neg_d;
			prod_s2  <= prod_d;
		end
	end

	// exact x/255 for x below 65535
	always_comb begin
		logic [16:0] t;
		logic [8:0]  q;
		logic [8:0]  v;
		for (int i = 0; i < 3; i++) begin
			t = {1'b0, prod_s2[i]} + 17'd1 + {9'd0, prod_s2[i][15:8]};
			q = t[16:8];
			v = neg_s2[i] ? ({1'b0, bg_s2[8*i +: 8]} - q) : ({1'b0, bg_s2[8*i +: 8]} + q);
			blended[8*i +: 8] = v[7:0];
		end
		result_d = pass_s2 ? pixel_s2 : {ALPHA_OPAQUE, blended};
	end

	always_ff @(posedge clk) begin
		if (ctl.load_out) begin
			pixel_out <= result_d;
		end
	end

endmodule

/* rtl/alpha_composite_over_background.sv */
// alpha_composite_over_background: top level, config registers, position counters, handshake
// depends on acob_pkg and acob_blend
// pipeline: input, product and result registers lie between the input beat and out_valid
// throughput: one pixel per cycle unless out_ready stalls it; stalls hold only full stages
// reset: arst_n clears valids, counters and registers (fill_mode 0, background 0, width 1)
// no memories, so the block accepts pixels from the first cycle after reset

module alpha_composite_over_background import acob_pkg::*; #(
	parameter int unsigned CHECKER_CELL = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [31:0]       pixel_in,
	input  logic              frame_start,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [31:0]       pixel_out
);

	localparam int unsigned CW = (CHECKER_CELL > 1) ? $clog2(CHECKER_CELL) : 1;
	localparam int unsigned RW = $clog2(2 * CHECKER_CELL);

	logic [1:0]  fill_mode_q;
	logic [23:0] background_rgb_q;
	logic [15:0] image_width_q;

	logic [15:0]   column_q;
	logic [CW-1:0] cell_col_q;
	logic          col_par_q;
	logic [RW-1:0] row_q;

	logic        v_s1;
	logic        v_s2;
	logic        v_out_q;
	logic [31:0] pixel_s1;
	logic [23:0] bg_s1;
	logic        bypass_s1;

	logic        rdy_out;
	logic        rdy_s2;
	logic        in_beat;
	blend_ctl_t  ctl;

	logic [15:0]   col_eff;
	logic [CW-1:0] cell_eff;
	logic          par_eff;
	logic [RW-1:0] row_eff;
	logic          row_wrap;
	logic [7:0]    gray;
	logic [16:0]   col_inc;

	// config port
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_mode_q      <= MODE_PASS;
			background_rgb_q <= '0;
			image_width_q    <= WIDTH_RESET;
		end else if (psel && penable && pwrite && pready) begin
			case (paddr[3:2])
				REG_FILL_MODE:      fill_mode_q      <= pwdata[1:0];
				REG_BACKGROUND_RGB: background_rgb_q <= pwdata[23:0];
				REG_IMAGE_WIDTH:    image_width_q    <= pwdata[15:0];
				default:            ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_FILL_MODE:      prdata = {30'd0, fill_mode_q};
			REG_BACKGROUND_RGB: prdata = {8'd0, background_rgb_q};
			REG_IMAGE_WIDTH:    prdata = {16'd0, image_width_q};
			default:            prdata = '0;
		endcase
	end

	// handshake
	assign rdy_out  = !v_out_q || out_ready;
	assign rdy_s2   = !v_s2 || rdy_out;
	assign in_ready = !v_s1 || rdy_s2;
	assign in_beat  = in_valid && in_ready;
	assign ctl.load_s2  = v_s1 && rdy_s2;
	assign ctl.load_out = v_s2 && rdy_out;
	assign out_valid    = v_out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_out_q <= 1'b0;
		end else begin
			if (in_ready) v_s1 <= in_valid;
			if (rdy_s2)   v_s2 <= v_s1;
			if (rdy_out)  v_out_q <= v_s2;
		end
	end

	// position of the current pixel
	always_comb begin
		col_eff  = frame_start ? '0 : column_q;
		cell_eff = frame_start ? '0 : cell_col_q;
		par_eff  = frame_start ? 1'b0 : col_par_q;
		row_eff  = frame_start ? '0 : row_q;
		row_wrap = (row_eff == RW'(2 * CHECKER_CELL - 1));
		gray     = (par_eff ^ (row_eff >= RW'(CHECKER_CELL))) ? GRAY_LIGHT : GRAY_DARK;
		col_inc  = {1'b0, col_eff} + 17'd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q   <= '0;
			cell_col_q <= '0;
			col_par_q  <= 1'b0;
			row_q      <= '0;
		end else if (in_beat) begin
			if (col_inc >= {1'b0, image_width_q}) begin
				column_q   <= '0;
				cell_col_q <= '0;
				col_par_q  <= 1'b0;
				row_q      <= row_wrap ? '0 : row_eff + RW'(1);
			end else begin
				column_q <= col_inc[15:0];
				if (cell_eff == CW'(CHECKER_CELL - 1)) begin
					cell_col_q <= '0;
					col_par_q  <= !par_eff;
				end else begin
					cell_col_q <= cell_eff + CW'(1);
					col_par_q  <= par_eff;
				end
				row_q <= row_eff;
			end
		end
	end

	// input register with background choice
	always_ff @(posedge clk) begin
		if (in_beat) begin
			pixel_s1 <= pixel_in;
			case (fill_mode_q)
				MODE_SOLID: begin
					bg_s1     <= background_rgb_q;
					bypass_s1 <= 1'b0;
				end
				MODE_CHECKER: begin
					bg_s1     <= {gray, gray, gray};
					bypass_s1 <= 1'b0;
				end
				default: begin
					bg_s1     <= '0;
					bypass_s1 <= 1'b1;
				end
			endcase
		end
	end

	acob_blend u_blend (
		.clk       (clk),
		.ctl       (ctl),
		.pixel_s1  (pixel_s1),
		.bg_s1     (bg_s1),
		.bypass_s1 (bypass_s1),
		.pixel_out (pixel_out)
	);

	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		row_q <= RW'(2 * CHECKER_CELL - 1))
		else $error("row counter out of range");

	a_cell_range: assert property (@(posedge clk) disable iff (!arst_n)
		cell_col_q <= CW'(CHECKER_CELL - 1))
		else $error("cell column counter out of range");

	a_frame_col: assert property (@(posedge clk) disable iff (!arst_n)
		in_beat && frame_start |=>
		(column_q == (($past(image_width_q) <= 16'd1) ? 16'd0 : 16'd1)))
		else $error("column not restarted at frame start");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !rdy_s2 |=> v_s1 && $stable(pixel_s1))
		else $error("input stage lost a beat while stalled");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && !rdy_out |=> v_s2 && v_out_q)
		else $error("product stage lost a beat while stalled");

endmodule
